// ===== rtl/core/miller_rabin_prime_test_core_assert.svh =====
// Assertion macros for the Miller-Rabin prime test core.
`ifndef MILLER_RABIN_PRIME_TEST_CORE_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define MRPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define MRPT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/mrpt_pkg.sv =====
// Package with constants and helpers for the Miller-Rabin prime test core.
package mrpt_pkg;

  localparam int unsigned NUM_BITS_DEF   = 31;
  localparam int unsigned MAX_TRIALS_DEF = 16;

  localparam int unsigned LFSR_W = 32;
  localparam int unsigned TC_W   = 5;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [LFSR_W-1:0] LFSR_TAPS   = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] SEED_RESET  = 32'd1;
  localparam logic [TC_W-1:0]   TRIALS_RESET = 5'd10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRIAL_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED    = 8'd1;

  // One step of the right-shifting Galois LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    lfsr_next = (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
  endfunction

endpackage

// ===== rtl/core/mrpt_if.sv =====
// Handshake interfaces for the candidate, result and configuration channels.
interface mrpt_cand_if #(parameter int unsigned NUM_BITS = 31);
  logic                valid;
  logic                ready;
  logic [NUM_BITS-1:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface mrpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

interface mrpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/mrpt_modmul.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module mrpt_modmul import mrpt_pkg::*; #(
  parameter int unsigned NB = NUM_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NB-1:0] a_i,
  input  logic [NB-1:0] b_i,
  input  logic [NB-1:0] m_i,
  output logic          done_o,
  output logic [NB-1:0] res_o
);
  localparam int unsigned CW = $clog2(NB + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NB-1:0] acc_q, a_q, b_q, m_q;
  logic [NB:0]   dbl, dbl_r, sum, sum_r;

  // Horner step: acc = (2*acc + bit*a) mod m, both terms reduced by one subtract.
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum   = dbl_r + {1'b0, (b_q[NB-1] ? a_q : {NB{1'b0}})};
    sum_r = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
    end else if (busy_q) begin
      acc_q <= sum_r[NB-1:0];
      b_q   <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
endmodule

// ===== rtl/core/mrpt_moddiv.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module mrpt_moddiv import mrpt_pkg::*; #(
  parameter int unsigned NB = NUM_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LFSR_W-1:0] dividend_i,
  input  logic [NB-1:0]     divisor_i,
  output logic              done_o,
  output logic [NB-1:0]     rem_o
);
  localparam int unsigned CW = $clog2(LFSR_W + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [LFSR_W-1:0] dvd_q;
  logic [NB-1:0]     div_q, rem_q;
  logic [NB:0]       trial;

  always_comb begin
    trial = {rem_q, dvd_q[LFSR_W-1]};
    if (trial >= {1'b0, div_q}) trial = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(LFSR_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= trial[NB-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

// ===== rtl/core/miller_rabin_prime_test_core.sv =====
// Top level of the Miller-Rabin probable-prime test core.
//
// Usage: a candidate item enters on cand_i; exactly one result item, is_prime,
// leaves on res_o for each candidate, in order. cfg_i writes trial_count
// (index 0) and rng_seed (index 1); writing rng_seed also reloads the witness
// LFSR. Writes are taken at any time but belong to idle periods.
// Candidates 0 to 4, or a zero trial count, go straight to the final state.
// Otherwise the time is set by the bit-serial modular multiplier: each round
// takes a witness remainder, up to 2*NUM_BITS products for a^d mod n and up
// to s-1 squarings; a composite usually ends after one round.
// One candidate is worked on at a time; cand_i is ready whenever the core is
// idle, even while a finished result still waits in the output register.
// If res_o is stalled, the next result holds in its final state until the
// output register frees. Reset empties the output, sets trial_count to 10 and
// seed and LFSR to 1.
module miller_rabin_prime_test_core import mrpt_pkg::*; #(
  parameter int unsigned NUM_BITS   = NUM_BITS_DEF,
  parameter int unsigned MAX_TRIALS = MAX_TRIALS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrpt_cand_if.sink   cand_i,
  mrpt_res_if.source  res_o,
  mrpt_cfg_if.sink    cfg_i
);
  `include "miller_rabin_prime_test_core_assert.svh"

  localparam int unsigned NB = NUM_BITS;
  localparam int unsigned TW = $clog2(MAX_TRIALS + 1);
  localparam int unsigned SW = $clog2(NB);
  localparam int unsigned CW = $clog2(NB + 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECOMP  = 9'b000000010,
    S_DIV     = 9'b000000100,
    S_EXP     = 9'b000001000,
    S_EXP_SQ  = 9'b000010000,
    S_EXP_MUL = 9'b000100000,
    S_CHECK   = 9'b001000000,
    S_SQR     = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_e;

  state_e            state_q;
  logic [TC_W-1:0]   trials_q;
  logic [LFSR_W-1:0] seed_q, lfsr_q;
  logic [NB-1:0]     n_q, d_q, e_q, a_q, x_q;
  logic [SW-1:0]     s_q, j_q;
  logic [CW-1:0]     ebits_q;
  logic              started_q;
  logic [TW-1:0]     rounds_q, lim_q;
  logic              verdict_q, res_q, res_valid_q;
  logic              mm_go_q, mm_mul_q, mm_go_d, mm_mul_d;

  logic          mm_done, dv_done, cand_acc, res_load, cfg_acc, seed_wr, mm_wait;
  logic [NB-1:0] mm_res, dv_rem, nm1, nm4, cand_n;
  logic [TW-1:0] lim_new;
  logic          round_pass, round_fail, last_round, round_go;

  // Shared modular multiplier: squares x, or multiplies x by the witness.
  mrpt_modmul #(.NB(NB)) u_modmul (
    .clk_i, .rst_ni,
    .start_i (mm_go_q),
    .a_i     (x_q),
    .b_i     (mm_mul_q ? a_q : x_q),
    .m_i     (n_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  // Witness remainder: LFSR mod (n-4).
  mrpt_moddiv #(.NB(NB)) u_moddiv (
    .clk_i, .rst_ni,
    .start_i    (round_go),
    .dividend_i (lfsr_q),
    .divisor_i  (nm4),
    .done_o     (dv_done),
    .rem_o      (dv_rem)
  );

  assign cand_i.ready = (state_q == S_IDLE);
  assign cand_acc     = cand_i.valid && cand_i.ready;
  assign cand_n       = cand_i.candidate;
  assign cfg_i.ready  = 1'b1;
  assign cfg_acc      = cfg_i.valid && cfg_i.ready;
  assign seed_wr      = cfg_acc && (cfg_i.index == CFG_RNG_SEED);
  assign res_o.valid    = res_valid_q;
  assign res_o.is_prime = res_q;
  assign res_load       = (state_q == S_FIN) && (!res_valid_q || res_o.ready);
  assign mm_wait = (state_q == S_EXP_SQ) || (state_q == S_EXP_MUL) || (state_q == S_SQR);

  assign nm1 = n_q - NB'(1);
  assign nm4 = n_q - NB'(4);

  // Effective round count saturates at MAX_TRIALS.
  assign lim_new = (32'(trials_q) > 32'(MAX_TRIALS)) ? TW'(MAX_TRIALS) : TW'(trials_q);

  always_comb begin
    round_pass = 1'b0;
    round_fail = 1'b0;
    case (state_q)
      S_CHECK: begin
        if (x_q == NB'(1) || x_q == nm1) round_pass = 1'b1;
        else if (s_q <= SW'(1))          round_fail = 1'b1;
      end
      S_SQR: begin
        if (mm_done) begin
          if (mm_res == NB'(1))   round_fail = 1'b1;
          else if (mm_res == nm1) round_pass = 1'b1;
          else if ({1'b0, j_q} + (SW+1)'(1) >= {1'b0, s_q}) round_fail = 1'b1;
        end
      end
      default: ;
    endcase
    last_round = ({1'b0, rounds_q} + (TW+1)'(1)) == {1'b0, lim_q};
    round_go   = ((state_q == S_DECOMP) && d_q[0]) || (round_pass && !last_round);
  end

  // Multiplier launches: a square or a multiply during the exponent walk, and
  // one square per step of the squaring loop while the round is undecided.
  always_comb begin
    mm_go_d  = 1'b0;
    mm_mul_d = (state_q == S_EXP_SQ);
    case (state_q)
      S_EXP:    mm_go_d = (ebits_q != '0) && (started_q || e_q[NB-1]);
      S_EXP_SQ: mm_go_d = mm_done && e_q[NB-1];
      S_CHECK:  mm_go_d = !round_pass && !round_fail;
      S_SQR:    mm_go_d = mm_done && !round_pass && !round_fail;
      default:  mm_go_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      trials_q    <= TRIALS_RESET;
      seed_q      <= SEED_RESET;
      lfsr_q      <= SEED_RESET;
      res_valid_q <= 1'b0;
      mm_go_q     <= 1'b0;
      mm_mul_q    <= 1'b0;
      rounds_q    <= '0;
    end else begin
      mm_go_q  <= mm_go_d;
      mm_mul_q <= mm_mul_d;
      if (cfg_acc && cfg_i.index == CFG_TRIAL_COUNT) trials_q <= cfg_i.wdata[TC_W-1:0];
      if (seed_wr) seed_q <= cfg_i.wdata;
      if (round_go)     lfsr_q <= lfsr_next(lfsr_q);
      else if (seed_wr) lfsr_q <= cfg_i.wdata;
      res_valid_q <= res_load || (res_valid_q && !res_o.ready);

      if (round_go) begin
        state_q <= S_DIV;
        if (round_pass) rounds_q <= rounds_q + TW'(1);
      end else if (round_pass || round_fail) begin
        state_q <= S_FIN;
      end else begin
        case (state_q)
          S_IDLE: begin
            if (cand_acc) begin
              rounds_q <= '0;
              if (cand_n <= NB'(4) || lim_new == '0) state_q <= S_FIN;
              else                                  state_q <= S_DECOMP;
            end
          end
          S_DECOMP: ;
          S_DIV: if (dv_done) state_q <= S_EXP;
          S_EXP: begin
            if (ebits_q == '0) begin
              state_q <= S_CHECK;
            end else if (started_q || e_q[NB-1]) begin
              state_q <= S_EXP_SQ;
            end
          end
          S_EXP_SQ: begin
            if (mm_done) begin
              if (e_q[NB-1]) state_q <= S_EXP_MUL;
              else           state_q <= S_EXP;
            end
          end
          S_EXP_MUL: if (mm_done) state_q <= S_EXP;
          S_CHECK: state_q <= S_SQR;
          S_SQR: ;
          S_FIN: if (res_load) state_q <= S_IDLE;
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  // Datapath registers; control above decides when they move.
  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= verdict_q;
    if (round_pass && last_round) verdict_q <= 1'b1;
    if (round_fail)               verdict_q <= 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cand_acc) begin
          n_q       <= cand_n;
          d_q       <= cand_n - NB'(1);
          s_q       <= '0;
          lim_q     <= lim_new;
          verdict_q <= (cand_n == NB'(2) || cand_n == NB'(3) ||
                        (cand_n > NB'(4) && lim_new == '0));
        end
      end
      S_DECOMP: begin
        if (!d_q[0]) begin
          d_q <= d_q >> 1;
          s_q <= s_q + SW'(1);
        end
      end
      S_DIV: begin
        if (dv_done) begin
          a_q       <= dv_rem + NB'(2);
          x_q       <= NB'(1);
          e_q       <= d_q;
          ebits_q   <= CW'(NB);
          started_q <= 1'b0;
        end
      end
      S_EXP: begin
        if (ebits_q != '0) begin
          if (started_q || e_q[NB-1]) begin
            started_q <= 1'b1;
          end else begin
            e_q     <= e_q << 1;
            ebits_q <= ebits_q - CW'(1);
          end
        end
      end
      S_EXP_SQ: begin
        if (mm_done) begin
          x_q <= mm_res;
          if (!e_q[NB-1]) begin
            e_q     <= e_q << 1;
            ebits_q <= ebits_q - CW'(1);
          end
        end
      end
      S_EXP_MUL: begin
        if (mm_done) begin
          x_q     <= mm_res;
          e_q     <= e_q << 1;
          ebits_q <= ebits_q - CW'(1);
        end
      end
      S_CHECK: j_q <= SW'(1);
      S_SQR: begin
        if (mm_done) begin
          x_q <= mm_res;
          j_q <= j_q + SW'(1);
        end
      end
      default: ;
    endcase
  end

  // A zero seed has to leave the LFSR stuck at zero.
  logic seed_zero;
  assign seed_zero = (seed_q == '0);

  `MRPT_ASSERT_NEVER(a_mm_done_state, mm_done && !mm_wait, "multiplier finished outside a wait")
  `MRPT_ASSERT_NEVER(a_res_overwrite, res_load && res_valid_q && !res_o.ready, "result overwritten")
  `MRPT_ASSERT_NEVER(a_rounds_bound, rounds_q > lim_q && state_q != S_IDLE, "round count beyond limit")
  `MRPT_ASSERT(a_zero_seed_lfsr, (seed_zero && $past(seed_wr)) |-> lfsr_q == '0, "zero seed not loaded")
endmodule

// ===== tb/miller_rabin_prime_test_core_chk.sv =====
// Checker that predicts each primality verdict and compares it with the core's result items.
module miller_rabin_prime_test_core_chk import mrpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mrpt_cand_if cand,
  mrpt_res_if  res,
  mrpt_cfg_if  cfg,
  output int   errors_o,
  output int   pending_o
);

  localparam int unsigned SAT_TRIALS = MAX_TRIALS_DEF;
  localparam logic [31:0] WITNESS_TAPS = 32'h8020_0003;

  logic [TC_W-1:0]   rounds_q;
  logic [LFSR_W-1:0] witness_q;
  bit                verdicts_q[$];
  int                seen_results;

  assign pending_o = verdicts_q.size();

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = (r * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return r;
  endfunction

  // Runs the witness rounds and advances the witness register once per round run.
  function automatic bit prime_verdict(logic [NUM_BITS_DEF-1:0] cand_val);
    longint unsigned n, d, a, x;
    int s, rounds;
    bit pass, done;
    n = cand_val;
    if (n <= 1 || n == 4) return 1'b0;
    if (n <= 3) return 1'b1;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    rounds = (rounds_q > SAT_TRIALS) ? SAT_TRIALS : rounds_q;
    for (int i = 0; i < rounds; i++) begin
      a = 2 + (longint'(witness_q) % (n - 4));
      witness_q = {1'b0, witness_q[31:1]} ^ (witness_q[0] ? WITNESS_TAPS : 32'd0);
      x = pow_mod(a, d, n);
      pass = (x == 1) || (x == n - 1);
      done = pass;
      for (int j = 1; j < s && !done; j++) begin
        x = (x * x) % n;
        if (x == 1) done = 1'b1;
        else if (x == n - 1) begin
          pass = 1'b1;
          done = 1'b1;
        end
      end
      if (!pass) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH result %0d: %s", seen_results, what);
    errors_o++;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q     = TRIALS_RESET;
      witness_q    = SEED_RESET;
      seen_results = 0;
      verdicts_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_TRIAL_COUNT) rounds_q = cfg.wdata[TC_W-1:0];
        else if (cfg.index == CFG_RNG_SEED) witness_q = cfg.wdata;
      end
      if (res.valid && res.ready) begin
        if (verdicts_q.size() == 0) report_mismatch("result item with none expected");
        else begin
          bit want;
          want = verdicts_q.pop_front();
          if (res.is_prime !== want)
            report_mismatch($sformatf("is_prime %b, expected %b", res.is_prime, want));
        end
        seen_results++;
      end
      if (cand.valid && cand.ready) verdicts_q.push_back(prime_verdict(cand.candidate));
    end
  end

endmodule

// ===== tb/miller_rabin_prime_test_core_tb.sv =====
// Testbench top that drives candidates and configuration into the prime test core.
module miller_rabin_prime_test_core_tb;
  import mrpt_pkg::*;

  // No accepted item for this many cycles means the core hung. The slowest
  // item is a prime under sixteen rounds plus a long receiver hold, and this
  // limit leaves several times that margin.
  localparam int IDLE_LIMIT = 400000;
  localparam int LONG_HOLD  = 40000;

  logic clk_i;
  logic rst_ni;
  int   errors, pending;
  int   tx_idle_pct, rx_idle_pct;
  int   idle_cycles;
  int   items_sent;
  bit   hold_tgl, hold_seen;
  int   hold_left;
  int   directed_vals[12] = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 561, 1024, 65537};

  mrpt_cand_if #(.NUM_BITS(NUM_BITS_DEF)) cand ();
  mrpt_res_if  res ();
  mrpt_cfg_if  cfg ();

  miller_rabin_prime_test_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cand_i (cand),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  miller_rabin_prime_test_core_chk chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cand      (cand),
    .res       (res),
    .cfg       (cfg),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The result receiver. A toggle of hold_tgl starts one long stall that this
  // process counts down on its own, so the core fills and stops taking items.
  initial begin
    res.ready = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
  end
  always @(posedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= LONG_HOLD;
      res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (cand.valid && cand.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offers one candidate, with random idle cycles ahead of it. Ready is
  // sampled at the falling edge, where it is stable, and the item counts as
  // taken at the rising edge that follows.
  task automatic send_candidate(logic [NUM_BITS_DEF-1:0] n);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      cand.valid <= 1'b0;
      @(posedge clk_i);
    end
    cand.valid     <= 1'b1;
    cand.candidate <= n;
    do begin
      @(negedge clk_i);
      taken = cand.ready;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  task automatic end_burst();
    cand.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Register writes happen only once every verdict is back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    bit taken;
    end_burst();
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= value;
    do begin
      @(negedge clk_i);
      taken = cfg.ready;
      @(posedge clk_i);
    end while (!taken);
    cfg.valid <= 1'b0;
  endtask

  // Mostly small candidates keep exponents short; a few use the full width.
  function automatic logic [NUM_BITS_DEF-1:0] random_candidate();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5)  return NUM_BITS_DEF'($urandom_range(4));
    if (pick < 70) return NUM_BITS_DEF'($urandom_range(65535, 5));
    if (pick < 85) return NUM_BITS_DEF'($urandom_range(1 << 20, 5));
    return NUM_BITS_DEF'($urandom & 32'h7FFF_FFFF);
  endfunction

  // The long result stall, when asked for, starts once the registers are set,
  // so the sender keeps offering items into a core that cannot drain.
  task automatic random_phase(int count, int tx_pct, int rx_pct, bit long_hold);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_reg(CFG_TRIAL_COUNT, $urandom_range(16, 1));
    write_reg(CFG_RNG_SEED, $urandom | 32'd1);
    if (long_hold) hold_tgl <= ~hold_tgl;
    for (int i = 0; i < count; i++) send_candidate(random_candidate());
  endtask

  initial begin
    rst_ni         = 1'b0;
    cand.valid     = 1'b0;
    cand.candidate = '0;
    cfg.valid      = 1'b0;
    cfg.index      = '0;
    cfg.wdata      = '0;
    hold_tgl       = 1'b0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    items_sent     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset settings: the trivial answers below
    // five, small primes and composites, a Carmichael number, powers of two
    // (even values above four take the single-check path), and both ends of
    // the candidate range, all ones being the Mersenne prime 2^31-1.
    foreach (directed_vals[k])
      send_candidate(NUM_BITS_DEF'(directed_vals[k]));
    send_candidate(31'h4000_0000);
    send_candidate(31'h7FFF_FFFE);
    send_candidate(31'h7FFF_FFFF);

    // With no rounds at all every candidate above four passes.
    write_reg(CFG_TRIAL_COUNT, 32'd0);
    send_candidate(31'd25);
    send_candidate(31'h7FFF_FFFE);
    // A count beyond the maximum saturates to sixteen rounds.
    write_reg(CFG_TRIAL_COUNT, 32'd31);
    send_candidate(31'd97);
    send_candidate(31'd91);
    // A zero seed freezes the witness at two, so 2047, a strong
    // pseudoprime to base two, is reported prime.
    write_reg(CFG_RNG_SEED, 32'd0);
    send_candidate(31'd2047);
    send_candidate(31'd13);
    write_reg(CFG_TRIAL_COUNT, 32'd1);
    write_reg(CFG_RNG_SEED, 32'hFFFF_FFFF);
    send_candidate(31'h7FFF_FFFF);
    send_candidate(31'd2047);

    // Random part: sender idles lightly while the receiver idles heavily,
    // then the reverse, then full throughput.
    random_phase(25, 12, 76, 1'b1);
    random_phase(25, 76, 12, 1'b0);
    for (int i = 0; i < 4; i++) send_candidate(random_candidate());
    // The sender stops here until every verdict is back.
    end_burst();
    wait (pending == 0);
    random_phase(25, 0, 0, 1'b0);

    end_burst();
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d candidates over directed cases, saturated and zero round counts,",
             items_sent);
    $display("zero and full seeds, and three idling mixes with a long result stall.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_if.sv
rtl/core/mrpt_modmul.sv
rtl/core/mrpt_moddiv.sv
rtl/core/miller_rabin_prime_test_core.sv
tb/miller_rabin_prime_test_core_chk.sv
tb/miller_rabin_prime_test_core_tb.sv
